// ===== sv/dlp_pkg.sv =====
// Package: sizes, codes and helpers shared by the longest-path engine.
`default_nettype none
package dlp_pkg;
   localparam int MAX_NODES   = 4096;
   localparam int MAX_EDGES   = 16384;
   localparam int WEIGHT_BITS = 24;
   localparam int SUM_BITS    = 40;
   localparam int NODE_BITS   = $clog2(MAX_NODES);
   localparam int EDGE_BITS   = $clog2(MAX_EDGES);
   localparam int EPTR_BITS   = EDGE_BITS + 1;
   localparam int CNT_BITS    = NODE_BITS + 1;
   localparam int PEND_BITS   = EDGE_BITS + 1;

   localparam logic [EPTR_BITS-1:0] EDGE_NULL = EPTR_BITS'(MAX_EDGES);
   localparam logic [CNT_BITS-1:0]  NODE_LIM  = CNT_BITS'(MAX_NODES);
   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   localparam logic [1:0] OP_SET_WEIGHT = 2'd0;
   localparam logic [1:0] OP_ADD_EDGE   = 2'd1;
   localparam logic [1:0] OP_SOLVE      = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CYCLE   = 2'd1;
   localparam logic [1:0] ST_NO_NODE = 2'd2;
   localparam logic [1:0] ST_DROPPED = 2'd3;
endpackage
`default_nettype wire

// ===== sv/dlp_if.sv =====
// Channel interfaces: request, response and control-register write.
`default_nettype none
interface dlp_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            opcode;
   logic [dlp_pkg::NODE_BITS-1:0]         node_id;
   logic signed [dlp_pkg::WEIGHT_BITS-1:0] node_weight;
   logic [dlp_pkg::NODE_BITS-1:0]         edge_to;
   modport source (output valid, opcode, node_id, node_weight, edge_to, input ready);
   modport sink   (input valid, opcode, node_id, node_weight, edge_to, output ready);
endinterface

interface dlp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dlp_pkg::SUM_BITS-1:0] best_sum;
   logic [1:0]                          status;
   modport source (output valid, best_sum, status, input ready);
   modport sink   (input valid, best_sum, status, output ready);
endinterface

interface dlp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [dlp_pkg::CNT_BITS-1:0]      node_count;
   modport source (output valid, node_count, input ready);
   modport sink   (input valid, node_count, output ready);
endinterface
`default_nettype wire

// ===== sv/dlp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== sv/dag_longest_path_engine.sv =====
// Top level: DAG loader, topological sort and longest-path sequencer.
//
// Channels: req carries words that set a node weight or add an edge, or
// request a solve; rsp returns one word (best_sum, status) per solve; csr
// writes node_count and is always ready.
// A weight word is written directly, an edge word does an adjacency head
// read-modify-write. A solve walks the stores through one shared
// sequencer: zeroing the pending counts, the in-degree count over every
// node and edge, seeding, and the relaxation pass over every node and
// edge, then one final queue check before the result is emitted.
// Each step is bounded by the single registered read port of each store.
// After every solve, and after reset, the adjacency heads are swept to
// null, during which req is not ready.
// Reset is synchronous, active high; it drops rsp valid and starts the
// sweep. The result sits in an output register: loads are still accepted
// while rsp stalls, and a following solve waits to emit until the
// pending word has been taken.
`default_nettype none
module dag_longest_path_engine (
   input wire logic  clock,
   input wire logic  reset,
   dlp_req_if.sink   req_ch,
   dlp_rsp_if.source rsp_ch,
   dlp_csr_if.sink   csr_ch
);
   localparam int NB = dlp_pkg::NODE_BITS;
   localparam int EB = dlp_pkg::EDGE_BITS;
   localparam int PB = dlp_pkg::EPTR_BITS;
   localparam int CB = dlp_pkg::CNT_BITS;
   localparam int DB = dlp_pkg::PEND_BITS;
   localparam int WB = dlp_pkg::WEIGHT_BITS;
   localparam int SB = dlp_pkg::SUM_BITS;

   typedef enum logic [4:0] {
      S_IDLE, S_EDGE, S_CLR, S_ZERO, S_CH_RD, S_CH_DAT, S_CE_CHK, S_CE_DAT,
      S_CE_WR, S_IN_RD, S_IN_DAT, S_MQ, S_MU, S_MH, S_MCHK, S_MD, S_MV, S_FIN
   } state_type;

   state_type         state_ff;
   logic [CB-1:0]     ncount_ff, nlim_ff, idx_ff, head_ff, tail_ff;
   logic [NB-1:0]     clr_ff, v_ff, eid_ff, eto_ff;
   logic [PB-1:0]     eptr_ff, el_ff;
   logic signed [SB-1:0] pu_ff, best_ff, rsp_sum_ff;
   logic              sink_ff, ovf_ff, rsp_valid_ff;
   logic [1:0]        rsp_status_ff;

   logic          w_we, pb_we, pd_we, tp_we, ah_we, en_we, ed_we;
   logic [NB-1:0] w_wa, pb_wa, pd_wa, tp_wa, ah_wa, w_ra, pb_ra, pd_ra, tp_ra, ah_ra;
   logic [EB-1:0] e_wa, e_ra;
   logic [WB-1:0] w_wd, w_rd;
   logic [SB-1:0] pb_wd, pb_rd;
   logic [DB-1:0] pd_wd, pd_rd;
   logic [NB-1:0] tp_wd, tp_rd, ed_wd, ed_rd;
   logic [PB-1:0] ah_wd, ah_rd, en_wd, en_rd;

   logic              req_fire, idx_last;
   logic [CB-1:0]     idx_inc;
   logic signed [SB:0] sum_wide;
   logic signed [SB-1:0] cand, w_ext;
   logic [1:0]        fin_status;
   logic [CB-1:0]     csr_lim;

   assign req_ch.ready    = (state_ff == S_IDLE);
   assign req_fire        = req_ch.valid & req_ch.ready;
   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.best_sum = rsp_sum_ff;
   assign rsp_ch.status   = rsp_status_ff;

   assign idx_inc  = idx_ff + 1'b1;
   assign idx_last = (idx_inc == nlim_ff);
   assign csr_lim  = (ncount_ff > dlp_pkg::NODE_LIM) ? dlp_pkg::NODE_LIM : ncount_ff;
   assign w_ext    = SB'($signed(w_rd));
   assign sum_wide = {pu_ff[SB-1], pu_ff} + {w_ext[SB-1], w_ext};
   assign cand     = (sum_wide[SB] != sum_wide[SB-1]) ?
                     (sum_wide[SB] ? dlp_pkg::SUM_MIN : dlp_pkg::SUM_MAX) :
                     sum_wide[SB-1:0];

   always_comb begin
      priority if (nlim_ff == '0) fin_status = dlp_pkg::ST_NO_NODE;
      else if (tail_ff < nlim_ff) fin_status = dlp_pkg::ST_CYCLE;
      else if (ovf_ff) fin_status = dlp_pkg::ST_DROPPED;
      else fin_status = dlp_pkg::ST_OK;
   end

   always_comb begin
      w_we = 1'b0; pb_we = 1'b0; pd_we = 1'b0; tp_we = 1'b0;
      ah_we = 1'b0; en_we = 1'b0; ed_we = 1'b0;
      w_wa = req_ch.node_id; w_wd = req_ch.node_weight;
      pb_wa = v_ff; pb_wd = cand;
      pd_wa = v_ff; pd_wd = pd_rd - 1'b1;
      tp_wa = tail_ff[NB-1:0]; tp_wd = v_ff;
      ah_wa = eid_ff; ah_wd = el_ff;
      e_wa = el_ff[EB-1:0]; en_wd = ah_rd; ed_wd = eto_ff;
      w_ra = idx_ff[NB-1:0]; pb_ra = ed_rd; pd_ra = ed_rd;
      tp_ra = head_ff[NB-1:0]; ah_ra = idx_ff[NB-1:0];
      e_ra = eptr_ff[EB-1:0];
      unique case (state_ff)
         S_IDLE: begin
            ah_ra = req_ch.node_id;
            w_we  = req_fire && (req_ch.opcode == dlp_pkg::OP_SET_WEIGHT);
         end
         S_EDGE: begin
            en_we = 1'b1; ed_we = 1'b1; ah_we = 1'b1;
         end
         S_CLR: begin
            ah_we = 1'b1; ah_wa = clr_ff; ah_wd = dlp_pkg::EDGE_NULL;
         end
         S_ZERO: begin
            pd_we = 1'b1; pd_wa = idx_ff[NB-1:0]; pd_wd = '0;
         end
         S_CE_WR: begin
            pd_we = 1'b1; pd_wd = pd_rd + 1'b1;
         end
         S_IN_RD: begin
            pd_ra = idx_ff[NB-1:0];
         end
         S_IN_DAT: begin
            pb_we = 1'b1; pb_wa = idx_ff[NB-1:0];
            pb_wd = (pd_rd == '0) ? w_ext : dlp_pkg::SUM_MIN;
            tp_we = (pd_rd == '0); tp_wd = idx_ff[NB-1:0];
         end
         S_MU: begin
            pb_ra = tp_rd; ah_ra = tp_rd;
         end
         S_MD: begin
            w_ra = ed_rd;
         end
         S_MV: begin
            pb_we = (cand > $signed(pb_rd));
            pd_we = 1'b1;
            tp_we = (pd_rd == DB'(1)) && !tail_ff[CB-1];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         ncount_ff    <= '0;
         el_ff        <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            ncount_ff <= csr_ch.node_count;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  unique case (req_ch.opcode)
                     dlp_pkg::OP_ADD_EDGE: begin
                        if (el_ff[PB-1]) begin
                           ovf_ff <= 1'b1;
                        end else begin
                           eid_ff   <= req_ch.node_id;
                           eto_ff   <= req_ch.edge_to;
                           state_ff <= S_EDGE;
                        end
                     end
                     dlp_pkg::OP_SOLVE: begin
                        nlim_ff  <= csr_lim;
                        idx_ff   <= '0;
                        head_ff  <= '0;
                        tail_ff  <= '0;
                        best_ff  <= dlp_pkg::SUM_MIN;
                        state_ff <= (csr_lim == '0) ? S_FIN : S_ZERO;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_EDGE: begin
               el_ff    <= el_ff + 1'b1;
               state_ff <= S_IDLE;
            end
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) state_ff <= S_IDLE;
            end
            S_ZERO: begin
               idx_ff <= idx_last ? '0 : idx_inc;
               if (idx_last) state_ff <= S_CH_RD;
            end
            S_CH_RD: state_ff <= S_CH_DAT;
            S_CH_DAT: begin
               eptr_ff  <= ah_rd;
               state_ff <= S_CE_CHK;
            end
            S_CE_CHK: begin
               if (eptr_ff[PB-1]) begin
                  idx_ff   <= idx_last ? '0 : idx_inc;
                  state_ff <= idx_last ? S_IN_RD : S_CH_RD;
               end else begin
                  state_ff <= S_CE_DAT;
               end
            end
            S_CE_DAT: begin
               v_ff     <= ed_rd;
               eptr_ff  <= en_rd;
               state_ff <= (CB'(ed_rd) < nlim_ff) ? S_CE_WR : S_CE_CHK;
            end
            S_CE_WR: state_ff <= S_CE_CHK;
            S_IN_RD: state_ff <= S_IN_DAT;
            S_IN_DAT: begin
               if (pd_rd == '0) tail_ff <= tail_ff + 1'b1;
               idx_ff   <= idx_inc;
               state_ff <= idx_last ? S_MQ : S_IN_RD;
            end
            S_MQ: state_ff <= (head_ff < tail_ff) ? S_MU : S_FIN;
            S_MU: begin
               head_ff  <= head_ff + 1'b1;
               state_ff <= S_MH;
            end
            S_MH: begin
               pu_ff    <= $signed(pb_rd);
               eptr_ff  <= ah_rd;
               sink_ff  <= 1'b1;
               state_ff <= S_MCHK;
            end
            S_MCHK: begin
               if (eptr_ff[PB-1]) begin
                  if (sink_ff && (pu_ff > best_ff)) best_ff <= pu_ff;
                  state_ff <= S_MQ;
               end else begin
                  state_ff <= S_MD;
               end
            end
            S_MD: begin
               v_ff    <= ed_rd;
               eptr_ff <= en_rd;
               if (CB'(ed_rd) < nlim_ff) begin
                  sink_ff  <= 1'b0;
                  state_ff <= S_MV;
               end else begin
                  state_ff <= S_MCHK;
               end
            end
            S_MV: begin
               if (tp_we) tail_ff <= tail_ff + 1'b1;
               state_ff <= S_MCHK;
            end
            S_FIN: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= fin_status;
                  rsp_sum_ff    <= (fin_status == dlp_pkg::ST_CYCLE ||
                                    fin_status == dlp_pkg::ST_NO_NODE) ? '0 : best_ff;
                  el_ff    <= '0;
                  ovf_ff   <= 1'b0;
                  clr_ff   <= '0;
                  state_ff <= S_CLR;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   dlp_ram #(.WIDTH(WB), .DEPTH(dlp_pkg::MAX_NODES)) u_weight (
      .clock, .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd), .rd_addr(w_ra), .rd_data(w_rd));
   dlp_ram #(.WIDTH(SB), .DEPTH(dlp_pkg::MAX_NODES)) u_best (
      .clock, .wr_en(pb_we), .wr_addr(pb_wa), .wr_data(pb_wd), .rd_addr(pb_ra),
      .rd_data(pb_rd));
   dlp_ram #(.WIDTH(DB), .DEPTH(dlp_pkg::MAX_NODES)) u_pend (
      .clock, .wr_en(pd_we), .wr_addr(pd_wa), .wr_data(pd_wd), .rd_addr(pd_ra),
      .rd_data(pd_rd));
   dlp_ram #(.WIDTH(NB), .DEPTH(dlp_pkg::MAX_NODES)) u_topo (
      .clock, .wr_en(tp_we), .wr_addr(tp_wa), .wr_data(tp_wd), .rd_addr(tp_ra),
      .rd_data(tp_rd));
   dlp_ram #(.WIDTH(PB), .DEPTH(dlp_pkg::MAX_NODES)) u_head (
      .clock, .wr_en(ah_we), .wr_addr(ah_wa), .wr_data(ah_wd), .rd_addr(ah_ra),
      .rd_data(ah_rd));
   dlp_ram #(.WIDTH(PB), .DEPTH(dlp_pkg::MAX_EDGES)) u_next (
      .clock, .wr_en(en_we), .wr_addr(e_wa), .wr_data(en_wd), .rd_addr(e_ra),
      .rd_data(en_rd));
   dlp_ram #(.WIDTH(NB), .DEPTH(dlp_pkg::MAX_EDGES)) u_dest (
      .clock, .wr_en(ed_we), .wr_addr(e_wa), .wr_data(ed_wd), .rd_addr(e_ra),
      .rd_data(ed_rd));
endmodule
`default_nettype wire

// ===== sv/dlp_checker.sv =====
// Port-level checks for the longest-path engine, bound to the top level.
`default_nettype none
module dlp_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic signed [dlp_pkg::SUM_BITS-1:0] best_sum,
   input wire logic [1:0]                 status
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(best_sum) && $stable(status))
      else $error("response word changed while stalled");

   a_zero_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == dlp_pkg::ST_CYCLE || status == dlp_pkg::ST_NO_NODE)
      |-> best_sum == '0)
      else $error("nonzero sum on failed solve");

   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_reset_sweep: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request ready during clearing sweep");

   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid && !rsp_ready |=> !rsp_valid || $stable(best_sum))
      else $error("pending response overwritten");
endmodule

bind dag_longest_path_engine dlp_checker u_dlp_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .best_sum(rsp_ch.best_sum),
   .status(rsp_ch.status)
);
`default_nettype wire

// ===== verif/tb_dag_longest_path_engine.sv =====
// Testbench: directed and random graph loads and solves, checked word by word.
`timescale 1ns / 100ps
module tb_dag_longest_path_engine;

   typedef struct {
      bit                                      is_cfg;
      logic [dlp_pkg::CNT_BITS-1:0]            cnt;
      logic [1:0]                              op;
      logic [dlp_pkg::NODE_BITS-1:0]           id;
      logic signed [dlp_pkg::WEIGHT_BITS-1:0]  w;
      logic [dlp_pkg::NODE_BITS-1:0]           to;
      bit                                      chk;
      logic signed [dlp_pkg::SUM_BITS-1:0]     esum;
      logic [1:0]                              est;
   } row_type;

   typedef struct {
      logic signed [dlp_pkg::SUM_BITS-1:0] sum;
      logic [1:0]                          st;
   } path_res_type;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 400000;
   localparam int HOLD_CYCLES = 12000;

   logic clock = 0;
   logic reset = 1;
   always #2 clock = ~clock;

   dlp_req_if req_ch();
   dlp_rsp_if rsp_ch();
   dlp_csr_if csr_ch();

   dag_longest_path_engine dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // predictor state
   int unsigned node_cnt;
   longint      wt_tab[dlp_pkg::MAX_NODES];
   int          adj_tab[dlp_pkg::MAX_NODES];
   int          nxt_tab[dlp_pkg::MAX_EDGES];
   int          dst_tab[dlp_pkg::MAX_EDGES];
   int          edge_cnt;
   bit          edge_ovf;
   int          indeg[dlp_pkg::MAX_NODES];
   int          order[dlp_pkg::MAX_NODES];
   longint      best_tab[dlp_pkg::MAX_NODES];

   path_res_type expect_q[$];
   int          errors = 0;
   int          n_items = 0, n_words = 0, n_solves_ok = 0, n_cycles = 0, n_dropped = 0;
   bit          done = 0;
   bit          burst = 0;
   bit          hold_req = 0;

   // driven side-band for typed expectations
   bit                                  drv_chk = 0;
   logic signed [dlp_pkg::SUM_BITS-1:0] drv_sum = '0;
   logic [1:0]                          drv_st = '0;

   // weights that must be set before the next solve
   bit wt_set[dlp_pkg::MAX_NODES];

   function automatic void clear_graph();
      for (int i = 0; i < dlp_pkg::MAX_NODES; i++) begin
         adj_tab[i] = dlp_pkg::MAX_EDGES;
         indeg[i] = 0;
         wt_tab[i] = 0;
      end
      edge_cnt = 0;
      edge_ovf = 0;
   endfunction

   function automatic longint sat_add(longint a, longint b);
      longint s = a + b;
      longint hi = (longint'(1) <<< 39) - 1;
      if (s > hi) return hi;
      if (s < -hi - 1) return -hi - 1;
      return s;
   endfunction

   function automatic path_res_type solve_graph();
      path_res_type r;
      int n, tail, hd, u, v;
      longint best, cand;
      bit sink;
      n = node_cnt > dlp_pkg::MAX_NODES ? dlp_pkg::MAX_NODES : node_cnt;
      tail = 0;
      hd = 0;
      best = -(longint'(1) <<< 39);
      if (n == 0) begin
         r.sum = '0;
         r.st = dlp_pkg::ST_NO_NODE;
         clear_graph();
         return r;
      end
      for (int i = 0; i < n; i++) indeg[i] = 0;
      for (int i = 0; i < n; i++)
         for (int e = adj_tab[i]; e < dlp_pkg::MAX_EDGES; e = nxt_tab[e])
            if (dst_tab[e] < n) indeg[dst_tab[e]]++;
      for (int i = 0; i < n; i++) begin
         if (indeg[i] == 0) begin
            best_tab[i] = wt_tab[i];
            order[tail++] = i;
         end else begin
            best_tab[i] = -(longint'(1) <<< 39);
         end
      end
      while (hd < tail) begin
         u = order[hd++];
         sink = 1;
         for (int e = adj_tab[u]; e < dlp_pkg::MAX_EDGES; e = nxt_tab[e]) begin
            v = dst_tab[e];
            if (v >= n) continue;
            sink = 0;
            cand = sat_add(best_tab[u], wt_tab[v]);
            if (cand > best_tab[v]) best_tab[v] = cand;
            indeg[v]--;
            if (indeg[v] == 0 && tail < dlp_pkg::MAX_NODES) order[tail++] = v;
         end
         if (sink && best_tab[u] > best) best = best_tab[u];
      end
      if (tail < n) begin
         r.sum = '0;
         r.st = dlp_pkg::ST_CYCLE;
      end else begin
         r.sum = best[dlp_pkg::SUM_BITS-1:0];
         r.st = edge_ovf ? dlp_pkg::ST_DROPPED : dlp_pkg::ST_OK;
      end
      clear_graph();
      return r;
   endfunction

   // returns 1 when the word yields a result
   function automatic bit apply_word(logic [1:0] op, int id, longint w, int to,
                                     output path_res_type r);
      r = '{default: '0};
      case (op)
         dlp_pkg::OP_SET_WEIGHT: begin
            wt_tab[id] = w;
            return 0;
         end
         dlp_pkg::OP_ADD_EDGE: begin
            if (edge_cnt >= dlp_pkg::MAX_EDGES) begin
               edge_ovf = 1;
               return 0;
            end
            dst_tab[edge_cnt] = to;
            nxt_tab[edge_cnt] = adj_tab[id];
            adj_tab[id] = edge_cnt;
            edge_cnt++;
            return 0;
         end
         dlp_pkg::OP_SOLVE: begin
            r = solve_graph();
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   // monitor: predict on accepted words, check accepted results
   always @(posedge clock) begin
      path_res_type r, e;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) node_cnt = csr_ch.node_count;
         if (req_ch.valid && req_ch.ready) begin
            if (apply_word(req_ch.opcode, req_ch.node_id, longint'(req_ch.node_weight),
                           req_ch.edge_to, r)) begin
               if (drv_chk) begin
                  e.sum = drv_sum;
                  e.st = drv_st;
                  expect_q = {expect_q, e};
               end else begin
                  expect_q = {expect_q, r};
               end
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_words++;
            if (expect_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word sum=%0d status=%0d", $time,
                        rsp_ch.best_sum, rsp_ch.status);
            end else begin
               e = expect_q.pop_front();
               case (rsp_ch.status)
                  dlp_pkg::ST_OK: n_solves_ok++;
                  dlp_pkg::ST_CYCLE: n_cycles++;
                  dlp_pkg::ST_DROPPED: n_dropped++;
                  default: ;
               endcase
               if (rsp_ch.best_sum !== e.sum) begin
                  errors++;
                  $display("%0t: best_sum mismatch expected %0d actual %0d", $time,
                           e.sum, rsp_ch.best_sum);
               end
               if (rsp_ch.status !== e.st) begin
                  errors++;
                  $display("%0t: status mismatch expected %0d actual %0d", $time,
                           e.st, rsp_ch.status);
               end
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // response ready, with one long hold-off on request
   always @(posedge clock) begin
      int g;
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (hold_req && rsp_ch.valid) begin
         hold_req = 0;
         rsp_ch.ready <= 0;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_ch.ready <= 1;
      end else begin
         g = pick_gap();
         if (g > 0) begin
            rsp_ch.ready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_ch.ready <= 1;
      end
   end

   // watchdog on cycles with no handshake anywhere
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset || done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, idle_cycles);
         $display("dag_longest_path_engine test failed");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] op, int id,
                            logic signed [dlp_pkg::WEIGHT_BITS-1:0] w, int to,
                            bit chk = 0, logic signed [dlp_pkg::SUM_BITS-1:0] es = '0,
                            logic [1:0] est = dlp_pkg::ST_OK);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_ch.valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.opcode <= op;
      req_ch.node_id <= id[dlp_pkg::NODE_BITS-1:0];
      req_ch.node_weight <= w;
      req_ch.edge_to <= to[dlp_pkg::NODE_BITS-1:0];
      drv_chk <= chk;
      drv_sum <= es;
      drv_st <= est;
      if (op == dlp_pkg::OP_SET_WEIGHT) wt_set[id] = 1;
      if (op == dlp_pkg::OP_SOLVE) wt_set = '{default: 0};
      if (op != OP_UNUSED) n_items++;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 0;
      @(posedge clock);
      while (expect_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_count(int cnt);
      csr_ch.valid <= 1;
      csr_ch.node_count <= cnt[dlp_pkg::CNT_BITS-1:0];
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 0;
      @(posedge clock);
   endtask

   function automatic row_type cfg_row(int cnt);
      row_type r = '{default: '0};
      r.is_cfg = 1;
      r.cnt = cnt[dlp_pkg::CNT_BITS-1:0];
      return r;
   endfunction

   function automatic row_type wd_row(logic [1:0] op, int id, int w, int to, bit chk = 0,
                                      longint es = 0, logic [1:0] est = dlp_pkg::ST_OK);
      row_type r = '{default: '0};
      r.op = op;
      r.id = id[dlp_pkg::NODE_BITS-1:0];
      r.w = w[dlp_pkg::WEIGHT_BITS-1:0];
      r.to = to[dlp_pkg::NODE_BITS-1:0];
      r.chk = chk;
      r.esum = es[dlp_pkg::SUM_BITS-1:0];
      r.est = est;
      return r;
   endfunction

   // random graph cases: for each solve, weights for every node, edges, noise, then a solve
   task automatic random_case(int n, bit make_cycle, int solves);
      row_type q[$];
      row_type t;
      int perm[$];
      int j, a, b, ne;
      for (int s = 0; s < solves; s++) begin
         q = {};
         perm = {};
         for (int i = 0; i < n; i++) perm = {perm, i};
         perm.shuffle();
         for (int i = 0; i < n; i++)
            q = {q, wd_row(dlp_pkg::OP_SET_WEIGHT, i, $urandom, 0)};
         ne = n == 0 ? 0 : $urandom_range(0, 2 * n);
         for (int i = 0; i < ne && n > 1; i++) begin
            a = $urandom_range(0, n - 2);
            b = $urandom_range(a + 1, n - 1);
            q = {q, wd_row(dlp_pkg::OP_ADD_EDGE, perm[a], 0, perm[b])};
         end
         if (make_cycle && n > 1) begin
            q = {q, wd_row(dlp_pkg::OP_ADD_EDGE, perm[0], 0, perm[n - 1])};
            q = {q, wd_row(dlp_pkg::OP_ADD_EDGE, perm[n - 1], 0, perm[0])};
         end
         if ($urandom_range(0, 3) == 0)
            q = {q, wd_row(dlp_pkg::OP_ADD_EDGE, $urandom_range(0, 4095), 0,
                           $urandom_range(0, 4095))};
         if ($urandom_range(0, 3) == 0)
            q = {q, wd_row(dlp_pkg::OP_SET_WEIGHT, $urandom_range(0, 4095), $urandom, 0)};
         if ($urandom_range(0, 5) == 0)
            q = {q, wd_row(OP_UNUSED, $urandom, $urandom, $urandom)};
         for (int i = q.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = q[i];
            q[i] = q[j];
            q[j] = t;
         end
         foreach (q[i]) send_word(q[i].op, q[i].id, q[i].w, q[i].to);
         for (int i = 0; i < n; i++)
            if (!wt_set[i]) send_word(dlp_pkg::OP_SET_WEIGHT, i, $urandom, 0);
         send_word(dlp_pkg::OP_SOLVE, $urandom, $urandom, $urandom);
      end
   endtask

   row_type dir_tab[$];
   int   n_cfg = 0;
   int   n;

   initial begin
      req_ch.valid = 0;
      req_ch.opcode = dlp_pkg::OP_SET_WEIGHT;
      req_ch.node_id = '0;
      req_ch.node_weight = '0;
      req_ch.edge_to = '0;
      csr_ch.valid = 0;
      csr_ch.node_count = '0;
      rsp_ch.ready = 0;
      node_cnt = 0;
      clear_graph();
      wt_set = '{default: 0};
      repeat (12) @(posedge clock);
      reset <= 0;

      dir_tab = '{
         wd_row(dlp_pkg::OP_SOLVE, 0, 0, 0, 1, 0, dlp_pkg::ST_NO_NODE),
         cfg_row(1),
         wd_row(dlp_pkg::OP_SET_WEIGHT, 0, 8388607, 0),
         wd_row(dlp_pkg::OP_SOLVE, 0, 0, 0, 1, 8388607, dlp_pkg::ST_OK),
         wd_row(dlp_pkg::OP_SET_WEIGHT, 0, -8388608, 0),
         wd_row(dlp_pkg::OP_SOLVE, 4095, -1, 4095, 1, -8388608, dlp_pkg::ST_OK),
         cfg_row(2),
         wd_row(dlp_pkg::OP_SET_WEIGHT, 0, 5, 0),
         wd_row(dlp_pkg::OP_SET_WEIGHT, 1, 7, 0),
         wd_row(dlp_pkg::OP_ADD_EDGE, 0, 0, 1),
         wd_row(dlp_pkg::OP_ADD_EDGE, 1, 0, 0),
         wd_row(dlp_pkg::OP_SOLVE, 0, 0, 0, 1, 0, dlp_pkg::ST_CYCLE),
         wd_row(dlp_pkg::OP_SET_WEIGHT, 1, 2, 0),
         wd_row(dlp_pkg::OP_SET_WEIGHT, 0, 1, 0),
         wd_row(dlp_pkg::OP_ADD_EDGE, 0, 0, 1),
         wd_row(OP_UNUSED, 4095, -1, 4095),
         wd_row(dlp_pkg::OP_ADD_EDGE, 0, 0, 4095),
         wd_row(dlp_pkg::OP_ADD_EDGE, 4095, 0, 1),
         wd_row(dlp_pkg::OP_SOLVE, 0, 0, 0),
         cfg_row(3),
         wd_row(dlp_pkg::OP_SET_WEIGHT, 2, -3, 0),
         wd_row(dlp_pkg::OP_SET_WEIGHT, 0, -1, 0),
         wd_row(dlp_pkg::OP_SET_WEIGHT, 1, -2, 0),
         wd_row(dlp_pkg::OP_SOLVE, 0, 0, 0, 1, -1, dlp_pkg::ST_OK)
      };
      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_cfg) begin
            wait_idle();
            write_count(dir_tab[i].cnt);
            n_cfg++;
         end else begin
            send_word(dir_tab[i].op, dir_tab[i].id, dir_tab[i].w, dir_tab[i].to,
                      dir_tab[i].chk, dir_tab[i].esum, dir_tab[i].est);
         end
      end

      // response held off while three solves are offered
      wait_idle();
      write_count(4);
      hold_req = 1;
      random_case(4, 0, 3);

      while (n_items < 850) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0: n = 0;
            1: n = $urandom_range(40, 64);
            default: n = $urandom_range(1, 16);
         endcase
         write_count(n);
         n_cfg++;
         burst = $urandom_range(0, 4) == 0;
         random_case(n, $urandom_range(0, 7) == 0, $urandom_range(1, 2));
      end
      burst = 0;
      wait_idle();
      write_count(0);
      req_ch.valid <= 0;

      while (expect_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      done = 1;
      if (expect_q.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $time, expect_q.size());
      end
      $display("Covered %0d result words: %0d ok, %0d cyclic, %0d with dropped edges,",
               n_words, n_solves_ok, n_cycles, n_dropped);
      $display("over %0d node-count settings, a long response stall and random gaps.",
               n_cfg);
      if (errors == 0)
         $display("dag_longest_path_engine test passed");
      else
         $display("dag_longest_path_engine test failed");
      $finish;
   end
endmodule
